@@ hw/rtl/dsfs_pkg.sv @@
// Shared types and constants for the directional sprite frame sequencer.
// Holds sequence codes, configuration register indexes and the frame count bundle.
// No dependencies.
`timescale 1ns / 1ps

package dsfs_pkg;

    // Sequence codes; codes 5 to 7 are unused and never reached.
    localparam logic [2:0] SEQ_LEFT_LOOP   = 3'd0;
    localparam logic [2:0] SEQ_LEFT_TURN   = 3'd1;
    localparam logic [2:0] SEQ_CENTRE_LOOP = 3'd2;
    localparam logic [2:0] SEQ_RIGHT_TURN  = 3'd3;
    localparam logic [2:0] SEQ_RIGHT_LOOP  = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_FRAME_PERIOD       = 3'd0;
    localparam logic [2:0] REG_LEFT_LOOP_FRAMES   = 3'd1;
    localparam logic [2:0] REG_LEFT_TURN_FRAMES   = 3'd2;
    localparam logic [2:0] REG_CENTRE_LOOP_FRAMES = 3'd3;
    localparam logic [2:0] REG_RIGHT_TURN_FRAMES  = 3'd4;
    localparam logic [2:0] REG_RIGHT_LOOP_FRAMES  = 3'd5;

    localparam int PERIOD_W = 10;
    localparam int COUNT_W  = 4;
    localparam int CFG_W    = 10;

    // Raw configured frame counts of the five sequences.
    typedef struct packed {
        logic [COUNT_W-1:0] right_loop;
        logic [COUNT_W-1:0] right_turn;
        logic [COUNT_W-1:0] centre_loop;
        logic [COUNT_W-1:0] left_turn;
        logic [COUNT_W-1:0] left_loop;
    } frame_counts_t;

endpackage

@@ hw/rtl/dsfs_step.sv @@
// Next sequence and frame for one animation step of the sprite sequencer.
// Purely combinational; depends on dsfs_pkg for codes and the frame count bundle.
`timescale 1ns / 1ps

module dsfs_step #(
    parameter int MAX_FRAMES = 8
) (
    input  logic [2:0]                        cur_seq,
    input  logic [$clog2(MAX_FRAMES)-1:0]     cur_frame,
    input  logic signed [1:0]                 direction,
    input  dsfs_pkg::frame_counts_t           counts,
    output logic [2:0]                        nxt_seq,
    output logic [$clog2(MAX_FRAMES)-1:0]     nxt_frame
);

    localparam int FW = $clog2(MAX_FRAMES);
    localparam int CW = $clog2(MAX_FRAMES + 1);

    // A count of zero acts as one, a count above the maximum as the maximum.
    function automatic logic [CW-1:0] clamp(input logic [dsfs_pkg::COUNT_W-1:0] raw);
        logic [CW-1:0] c;
        if (raw == '0) begin
            c = CW'(1);
        end else if (32'(raw) > MAX_FRAMES) begin
            c = CW'(MAX_FRAMES);
        end else begin
            c = CW'(raw);
        end
        return c;
    endfunction

    logic [CW-1:0] n_left_loop;
    logic [CW-1:0] n_left_turn;
    logic [CW-1:0] n_centre_loop;
    logic [CW-1:0] n_right_turn;
    logic [CW-1:0] n_right_loop;
    logic [CW-1:0] fwd_frame;
    logic [FW-1:0] fwd_trunc;
    logic [FW-1:0] back_frame;
    logic [FW-1:0] left_turn_last;
    logic [FW-1:0] right_turn_last;
    logic          at_first;

    assign n_left_loop   = clamp(counts.left_loop);
    assign n_left_turn   = clamp(counts.left_turn);
    assign n_centre_loop = clamp(counts.centre_loop);
    assign n_right_turn  = clamp(counts.right_turn);
    assign n_right_loop  = clamp(counts.right_loop);

    // Candidate frames for a forward step, a backward step and a transition entry.
    assign fwd_frame       = CW'(cur_frame) + CW'(1);
    assign fwd_trunc       = FW'(fwd_frame);
    assign back_frame      = cur_frame - FW'(1);
    assign at_first        = (cur_frame == '0);
    assign left_turn_last  = FW'(n_left_turn - CW'(1));
    assign right_turn_last = FW'(n_right_turn - CW'(1));

    // Step table by direction and current sequence.
    always_comb begin
        nxt_seq   = cur_seq;
        nxt_frame = cur_frame;
        priority if (direction == 2'sd0) begin
            unique case (cur_seq)
                dsfs_pkg::SEQ_LEFT_LOOP: begin
                    nxt_seq   = dsfs_pkg::SEQ_LEFT_TURN;
                    nxt_frame = left_turn_last;
                end
                dsfs_pkg::SEQ_LEFT_TURN, dsfs_pkg::SEQ_RIGHT_TURN: begin
                    if (at_first) begin
                        nxt_seq   = dsfs_pkg::SEQ_CENTRE_LOOP;
                        nxt_frame = '0;
                    end else begin
                        nxt_frame = back_frame;
                    end
                end
                dsfs_pkg::SEQ_CENTRE_LOOP: begin
                    nxt_frame = (fwd_frame >= n_centre_loop) ? '0 : fwd_trunc;
                end
                dsfs_pkg::SEQ_RIGHT_LOOP: begin
                    nxt_seq   = dsfs_pkg::SEQ_RIGHT_TURN;
                    nxt_frame = right_turn_last;
                end
                default: begin
                end
            endcase
        end else if (direction[1]) begin
            // Any negative pattern counts as left.
            unique case (cur_seq)
                dsfs_pkg::SEQ_LEFT_LOOP: begin
                    nxt_frame = (fwd_frame >= n_left_loop) ? '0 : fwd_trunc;
                end
                dsfs_pkg::SEQ_LEFT_TURN: begin
                    if (fwd_frame >= n_left_turn) begin
                        nxt_seq   = dsfs_pkg::SEQ_LEFT_LOOP;
                        nxt_frame = '0;
                    end else begin
                        nxt_frame = fwd_trunc;
                    end
                end
                dsfs_pkg::SEQ_CENTRE_LOOP: begin
                    nxt_seq   = dsfs_pkg::SEQ_LEFT_TURN;
                    nxt_frame = '0;
                end
                dsfs_pkg::SEQ_RIGHT_TURN: begin
                    if (at_first) begin
                        nxt_seq   = dsfs_pkg::SEQ_LEFT_TURN;
                        nxt_frame = '0;
                    end else begin
                        nxt_frame = back_frame;
                    end
                end
                dsfs_pkg::SEQ_RIGHT_LOOP: begin
                    nxt_seq   = dsfs_pkg::SEQ_RIGHT_TURN;
                    nxt_frame = right_turn_last;
                end
                default: begin
                end
            endcase
        end else begin
            unique case (cur_seq)
                dsfs_pkg::SEQ_LEFT_LOOP: begin
                    nxt_seq   = dsfs_pkg::SEQ_LEFT_TURN;
                    nxt_frame = left_turn_last;
                end
                dsfs_pkg::SEQ_LEFT_TURN: begin
                    if (at_first) begin
                        nxt_seq   = dsfs_pkg::SEQ_RIGHT_TURN;
                        nxt_frame = '0;
                    end else begin
                        nxt_frame = back_frame;
                    end
                end
                dsfs_pkg::SEQ_CENTRE_LOOP: begin
                    nxt_seq   = dsfs_pkg::SEQ_RIGHT_TURN;
                    nxt_frame = '0;
                end
                dsfs_pkg::SEQ_RIGHT_TURN: begin
                    if (fwd_frame >= n_right_turn) begin
                        nxt_seq   = dsfs_pkg::SEQ_RIGHT_LOOP;
                        nxt_frame = '0;
                    end else begin
                        nxt_frame = fwd_trunc;
                    end
                end
                dsfs_pkg::SEQ_RIGHT_LOOP: begin
                    nxt_frame = (fwd_frame >= n_right_loop) ? '0 : fwd_trunc;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/directional_sprite_frame_sequencer.sv @@
// Top level of the directional sprite frame sequencer: config registers, tick divider,
// sequencer state and the output register. Depends on dsfs_pkg and dsfs_step.
// Latency: a result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while m_tready drains the output; the state update is one pass through dsfs_step.
// A new beat is taken while the output register drains in the same cycle.
// Reset (aresetn low, synchronous): centre loop, frame 0, period and counts 1.
`timescale 1ns / 1ps

module directional_sprite_frame_sequencer #(
    parameter int MAX_FRAMES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [dsfs_pkg::CFG_W-1:0] cfg_wr_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] direction (signed), [7:2] zero

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [2:0] sequence_index, [5:3] frame_index,
                                   // [6] stepped, [7] zero
);

    localparam int FW = $clog2(MAX_FRAMES);

    logic [dsfs_pkg::PERIOD_W-1:0] period_reg;
    logic [dsfs_pkg::PERIOD_W-1:0] div_reg;
    dsfs_pkg::frame_counts_t       counts_reg;
    logic [2:0]                    seq_reg;
    logic [2:0]                    seq_next;
    logic [FW-1:0]                 frame_reg;
    logic [FW-1:0]                 frame_next;
    logic                          m_valid_reg;
    logic [2:0]                    out_seq_reg;
    logic [2:0]                    out_frame_reg;
    logic                          out_stepped_reg;

    logic                          in_acc;
    logic                          expire;
    logic signed [1:0]             direction;
    logic [dsfs_pkg::PERIOD_W-1:0] eff_period;
    logic [dsfs_pkg::PERIOD_W-1:0] wr_period;
    logic [dsfs_pkg::PERIOD_W-1:0] wr_eff_period;

    // Handshake: take a beat whenever the output register is empty or draining.
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_acc    = s_tvalid && s_tready;
    assign direction = s_tdata[1:0];

    // A period of zero behaves as one.
    assign eff_period    = (period_reg == '0) ? dsfs_pkg::PERIOD_W'(1) : period_reg;
    assign wr_period     = cfg_wr_data[dsfs_pkg::PERIOD_W-1:0];
    assign wr_eff_period = (wr_period == '0) ? dsfs_pkg::PERIOD_W'(1) : wr_period;
    assign expire        = (div_reg <= dsfs_pkg::PERIOD_W'(1));

    // Configuration registers; a period write also reloads the divider.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= dsfs_pkg::PERIOD_W'(1);
            div_reg     <= dsfs_pkg::PERIOD_W'(1);
            counts_reg  <= '{default: dsfs_pkg::COUNT_W'(1)};
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    dsfs_pkg::REG_FRAME_PERIOD:       period_reg <= wr_period;
                    dsfs_pkg::REG_LEFT_LOOP_FRAMES:
                        counts_reg.left_loop   <= cfg_wr_data[dsfs_pkg::COUNT_W-1:0];
                    dsfs_pkg::REG_LEFT_TURN_FRAMES:
                        counts_reg.left_turn   <= cfg_wr_data[dsfs_pkg::COUNT_W-1:0];
                    dsfs_pkg::REG_CENTRE_LOOP_FRAMES:
                        counts_reg.centre_loop <= cfg_wr_data[dsfs_pkg::COUNT_W-1:0];
                    dsfs_pkg::REG_RIGHT_TURN_FRAMES:
                        counts_reg.right_turn  <= cfg_wr_data[dsfs_pkg::COUNT_W-1:0];
                    dsfs_pkg::REG_RIGHT_LOOP_FRAMES:
                        counts_reg.right_loop  <= cfg_wr_data[dsfs_pkg::COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            // Divider: reload on a period write, otherwise count ticks.
            if (cfg_wr_en && (cfg_addr == dsfs_pkg::REG_FRAME_PERIOD)) begin
                div_reg <= wr_eff_period;
            end else if (in_acc) begin
                div_reg <= expire ? eff_period : (div_reg - dsfs_pkg::PERIOD_W'(1));
            end
        end
    end

    // Step table.
    dsfs_step #(
        .MAX_FRAMES(MAX_FRAMES)
    ) u_step (
        .cur_seq   (seq_reg),
        .cur_frame (frame_reg),
        .direction (direction),
        .counts    (counts_reg),
        .nxt_seq   (seq_next),
        .nxt_frame (frame_next)
    );

    // Sequencer state advances only on an accepted beat when the divider expires.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg   <= dsfs_pkg::SEQ_CENTRE_LOOP;
            frame_reg <= '0;
        end else if (in_acc && expire) begin
            seq_reg   <= seq_next;
            frame_reg <= frame_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_acc) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload carries the state after this tick.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            out_seq_reg     <= expire ? seq_next : seq_reg;
            out_frame_reg   <= expire ? 3'(frame_next) : 3'(frame_reg);
            out_stepped_reg <= expire;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_stepped_reg, out_frame_reg, out_seq_reg};

    // A held result blocks new beats.
    a_hold_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while result beat is stalled");

    // Without expiry or a period write the divider counts down by one.
    a_divider_counts: assert property (@(posedge aclk)
        (aresetn && in_acc && !expire && !cfg_wr_en) |=>
        (!aresetn || div_reg == $past(div_reg) - dsfs_pkg::PERIOD_W'(1)))
        else $error("tick divider did not decrement");

    // The sequencer state moves only on a step.
    a_state_only_on_step: assert property (@(posedge aclk)
        (aresetn && !(in_acc && expire)) |=>
        (!aresetn || ($stable(seq_reg) && $stable(frame_reg))))
        else $error("sequencer state changed without a step");

    // An expiring beat produces a result marked as stepped.
    a_step_flagged: assert property (@(posedge aclk)
        (aresetn && in_acc && expire) |=> (!aresetn || (m_valid_reg && out_stepped_reg)))
        else $error("step not flagged in result beat");

endmodule
